>>> rtl/tfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tfe_pkg;

    localparam int unsigned AmtW       = 64;
    localparam int unsigned BpW        = 16;
    localparam int unsigned LenW       = 16;
    localparam int unsigned ByteW      = 8;

    localparam int unsigned ExtStart   = 166;
    localparam int unsigned PreW       = $clog2(ExtStart + 1);
    localparam int unsigned FeeExtType = 1;
    localparam int unsigned FeeMinLen  = 108;
    localparam int unsigned MaxFeeOfs  = 98;
    localparam int unsigned BpOfs      = 106;

    localparam int unsigned Divisor    = 10000;
    localparam int unsigned DivW       = $clog2(Divisor);
    localparam int unsigned QuotW      = AmtW - (DivW - 1);
    localparam int unsigned HiW        = QuotW + BpW;
    localparam int unsigned SumW       = HiW + 1;
    localparam int unsigned LoProdW    = DivW + BpW;
    localparam int unsigned RecipShift = LoProdW + DivW;
    localparam int unsigned RecipW     = RecipShift - DivW + 1;
    localparam int unsigned RecipProdW = LoProdW + RecipW;
    localparam logic [63:0] RecipMul64 =
        ((64'd1 << RecipShift) + 64'(Divisor) - 64'd1) / 64'(Divisor);
    localparam logic [RecipW-1:0] RecipMul = RecipMul64[RecipW-1:0];

    localparam int unsigned DigW       = 16;
    localparam int unsigned NumDig     = AmtW / DigW;
    localparam int unsigned DigCntW    = $clog2(NumDig);
    localparam int unsigned DigDivW    = DivW + DigW;
    localparam int unsigned DigProdW   = DigDivW + RecipW;

    localparam int unsigned QDepth     = 4;
    localparam int unsigned QAw        = $clog2(QDepth);

    localparam int unsigned OutDataW   = BpW + AmtW + AmtW;

    typedef struct packed {
        logic             found;
        logic [BpW-1:0]   bp;
        logic [AmtW-1:0]  max_fee;
    } t_fee_rec;

    typedef struct packed {
        logic [QuotW-1:0] quot;
        logic [DivW-1:0]  rem;
    } t_amt_split;

endpackage

`default_nettype wire

>>> rtl/tlv_transfer_fee_extractor_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Scans an account record one byte per beat (tlast on its final byte) and,
// for each record, returns one result beat with the transfer-fee settings of
// the first type-1 extension of at least 108 bytes that lies wholly inside
// it, plus min(floor(amount*bp/10000), max fee). The input takes one byte
// every cycle unless the queue is full or a division is running, and a
// four-entry queue between the parser and the estimate pipeline absorbs
// output back-pressure. Writing the transfer amount starts a division of it
// by 10000, one 16-bit digit at a time; the byte input and the configuration
// port are held not ready until that division completes.

module tlv_transfer_fee_extractor_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [7:0]                    i_s_tdata,   // data_byte
    input  wire logic                          i_s_tlast,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // fee_basis_points, max_fee_raw, estimated_fee_raw
    output logic [tfe_pkg::OutDataW-1:0]       o_m_tdata,
    output logic                               o_m_tuser,   // fee_found
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [tfe_pkg::AmtW-1:0]      i_cfg_data   // transfer_amount
);

    logic                   div_busy;
    tfe_pkg::t_amt_split    split;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    logic                   push;
    tfe_pkg::t_fee_rec      push_rec;
    tfe_pkg::t_fee_rec      head_rec;
    logic                   s_beat;

    assign o_s_tready  = !q_full && !div_busy;
    assign o_cfg_ready = !div_busy;
    assign s_beat      = i_s_tvalid && o_s_tready;

    tfe_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (i_cfg_valid && o_cfg_ready),
        .i_amount (i_cfg_data),
        .o_busy   (div_busy),
        .o_split  (split)
    );

    tfe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (s_beat),
        .i_byte  (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_push  (push),
        .o_rec   (push_rec)
    );

    tfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (q_pop),
        .o_rec   (head_rec),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    tfe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_split (split),
        .i_rec   (head_rec),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_found (o_m_tuser)
    );

endmodule

`default_nettype wire

>>> rtl/tfe_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tfe_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_beat,
    input  wire logic [tfe_pkg::ByteW-1:0] i_byte,
    input  wire logic                     i_last,
    output logic                          o_push,
    output tfe_pkg::t_fee_rec             o_rec
);

    typedef enum logic [2:0] {
        PH_PRE  = 3'b001,
        PH_HDR  = 3'b010,
        PH_BODY = 3'b100
    } t_phase;

    t_phase                         r_phase, n_phase;
    logic [tfe_pkg::PreW-1:0]       r_pre,   n_pre;
    logic [23:0]                    r_hdr,   n_hdr;
    logic [tfe_pkg::LenW-1:0]       r_off,   n_off;
    logic [tfe_pkg::LenW-1:0]       r_len,   n_len;
    logic                           r_qual,  n_qual;
    logic [tfe_pkg::BpW-1:0]        r_bp,    n_bp;
    logic [tfe_pkg::AmtW-1:0]       r_max,   n_max;
    logic                           r_done,  n_done;

    logic [tfe_pkg::LenW-1:0]       hdr_type;
    logic [tfe_pkg::LenW-1:0]       hdr_len;
    logic [tfe_pkg::LenW-1:0]       off_inc;
    logic [tfe_pkg::LenW-1:0]       fee_idx;

    assign hdr_type = r_hdr[15:0];
    assign hdr_len  = {i_byte, r_hdr[23:16]};
    assign off_inc  = r_off + 1'b1;
    assign fee_idx  = r_off - tfe_pkg::LenW'(tfe_pkg::MaxFeeOfs);

    always_comb begin
        n_phase = r_phase;
        n_pre   = r_pre;
        n_hdr   = r_hdr;
        n_off   = r_off;
        n_len   = r_len;
        n_qual  = r_qual;
        n_bp    = r_bp;
        n_max   = r_max;
        n_done  = r_done;
        o_push  = 1'b0;
        o_rec   = '0;

        if (i_beat && !r_done) begin
            unique case (r_phase)
                PH_PRE: begin
                    n_pre = r_pre + 1'b1;
                    if (n_pre == tfe_pkg::PreW'(tfe_pkg::ExtStart)) begin
                        n_phase = PH_HDR;
                        n_off   = '0;
                    end
                end
                PH_HDR: begin
                    case (r_off[1:0])
                        2'd0: n_hdr[7:0]   = i_byte;
                        2'd1: n_hdr[15:8]  = i_byte;
                        2'd2: n_hdr[23:16] = i_byte;
                        default: begin
                            n_off  = '0;
                            n_len  = hdr_len;
                            n_qual = (hdr_type == tfe_pkg::LenW'(tfe_pkg::FeeExtType)) &&
                                     (hdr_len >= tfe_pkg::LenW'(tfe_pkg::FeeMinLen));
                            if (n_qual) begin
                                n_bp  = '0;
                                n_max = '0;
                            end
                            n_phase = (hdr_len == '0) ? PH_HDR : PH_BODY;
                        end
                    endcase
                    if (r_off[1:0] != 2'd3) begin
                        n_off = off_inc;
                    end
                end
                PH_BODY: begin
                    if (r_qual) begin
                        if (r_off >= tfe_pkg::LenW'(tfe_pkg::MaxFeeOfs) &&
                            r_off <  tfe_pkg::LenW'(tfe_pkg::MaxFeeOfs + 8)) begin
                            n_max[fee_idx[2:0]*8 +: 8] = i_byte;
                        end else if (r_off == tfe_pkg::LenW'(tfe_pkg::BpOfs)) begin
                            n_bp[7:0] = i_byte;
                        end else if (r_off == tfe_pkg::LenW'(tfe_pkg::BpOfs + 1)) begin
                            n_bp[15:8] = i_byte;
                        end
                    end
                    n_off = off_inc;
                    if (off_inc == r_len) begin
                        if (r_qual) begin
                            n_done = 1'b1;
                        end else begin
                            n_phase = PH_HDR;
                            n_off   = '0;
                        end
                    end
                end
                default: n_phase = PH_PRE;
            endcase
        end

        if (i_beat && i_last) begin
            o_push        = 1'b1;
            o_rec.found   = n_done && (n_bp != '0);
            o_rec.bp      = o_rec.found ? n_bp  : '0;
            o_rec.max_fee = o_rec.found ? n_max : '0;
            n_phase = PH_PRE;
            n_pre   = '0;
            n_off   = '0;
            n_len   = '0;
            n_qual  = 1'b0;
            n_bp    = '0;
            n_max   = '0;
            n_done  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PRE;
            r_pre   <= '0;
            r_hdr   <= '0;
            r_off   <= '0;
            r_len   <= '0;
            r_qual  <= 1'b0;
            r_bp    <= '0;
            r_max   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pre   <= n_pre;
            r_hdr   <= n_hdr;
            r_off   <= n_off;
            r_len   <= n_len;
            r_qual  <= n_qual;
            r_bp    <= n_bp;
            r_max   <= n_max;
            r_done  <= n_done;
        end
    end

    a_done_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_phase == PH_BODY) && r_qual)
        else $error("search ended outside a qualifying body");

    a_pre_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PRE) |-> !r_qual && (r_off == '0) && !r_done)
        else $error("preamble with stale record state");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_phase == PH_PRE) && !r_done && (r_pre == '0))
        else $error("record state not cleared after last beat");

endmodule

`default_nettype wire

>>> rtl/tfe_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tfe_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  tfe_pkg::t_fee_rec      i_rec,
    input  wire logic              i_pop,
    output tfe_pkg::t_fee_rec      o_rec,
    output logic                   o_empty,
    output logic                   o_full
);

    tfe_pkg::t_fee_rec          r_mem [tfe_pkg::QDepth];
    logic [tfe_pkg::QAw:0]      r_wp;
    logic [tfe_pkg::QAw:0]      r_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[tfe_pkg::QAw] != r_rp[tfe_pkg::QAw]) &&
                     (r_wp[tfe_pkg::QAw-1:0] == r_rp[tfe_pkg::QAw-1:0]);
    assign o_rec   = r_mem[r_rp[tfe_pkg::QAw-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp[tfe_pkg::QAw-1:0]] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/tfe_div.sv
`timescale 1ns / 1ps
`default_nettype none

module tfe_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_wr,
    input  wire logic [tfe_pkg::AmtW-1:0] i_amount,
    output logic                          o_busy,
    output tfe_pkg::t_amt_split           o_split
);

    logic                           r_busy;
    logic                           r_ph;
    logic [tfe_pkg::DigCntW-1:0]    r_cnt;
    logic [tfe_pkg::AmtW-1:0]       r_acc;
    logic [tfe_pkg::QuotW-1:0]      r_quot;
    logic [tfe_pkg::DivW-1:0]       r_rem;
    logic [tfe_pkg::DigW-1:0]       r_dig;

    logic [tfe_pkg::DigDivW-1:0]    part;
    logic [tfe_pkg::DigProdW-1:0]   part_prod;
    logic [tfe_pkg::DigDivW-1:0]    part_rem;

    // long division by 10000, one 16-bit digit at a time by reciprocal multiply
    assign part      = {r_rem, r_acc[tfe_pkg::AmtW-1 -: tfe_pkg::DigW]};
    assign part_prod = tfe_pkg::DigProdW'(part) * tfe_pkg::DigProdW'(tfe_pkg::RecipMul);
    assign part_rem  = part - tfe_pkg::DigDivW'(r_dig) *
                              tfe_pkg::DigDivW'(tfe_pkg::Divisor);

    assign o_busy        = r_busy;
    assign o_split.quot  = r_quot;
    assign o_split.rem   = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= 1'b0;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_quot <= '0;
            r_rem  <= '0;
            r_dig  <= '0;
        end else if (i_wr) begin
            r_busy <= 1'b1;
            r_ph   <= 1'b0;
            r_cnt  <= '0;
            r_acc  <= i_amount;
            r_quot <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            if (!r_ph) begin
                r_dig <= part_prod[tfe_pkg::RecipShift +: tfe_pkg::DigW];
                r_ph  <= 1'b1;
            end else begin
                r_rem  <= part_rem[tfe_pkg::DivW-1:0];
                r_quot <= {r_quot[tfe_pkg::QuotW-tfe_pkg::DigW-1:0], r_dig};
                r_acc  <= r_acc << tfe_pkg::DigW;
                r_ph   <= 1'b0;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == tfe_pkg::DigCntW'(tfe_pkg::NumDig - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/tfe_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tfe_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  tfe_pkg::t_amt_split                i_split,
    input  tfe_pkg::t_fee_rec                  i_rec,
    input  wire logic                          i_empty,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [tfe_pkg::OutDataW-1:0]       o_data,
    output logic                               o_found
);

    logic                               adv;

    logic                               r_v1;
    logic [tfe_pkg::HiW-1:0]            r_hi1;
    logic [tfe_pkg::LoProdW-1:0]        r_plo1;
    tfe_pkg::t_fee_rec                  r_rec1;

    logic                               r_v2;
    logic [tfe_pkg::HiW-1:0]            r_hi2;
    logic [tfe_pkg::BpW-1:0]            r_lo2;
    tfe_pkg::t_fee_rec                  r_rec2;

    logic                               r_ov;
    tfe_pkg::t_fee_rec                  r_orec;
    logic [tfe_pkg::AmtW-1:0]           r_est;

    logic [tfe_pkg::RecipProdW-1:0]     recip_prod;
    logic [tfe_pkg::SumW-1:0]           sum;
    logic [tfe_pkg::AmtW-1:0]           est;

    assign adv   = !r_ov || i_ready;
    assign o_pop = adv && !i_empty;

    // floor(r*bp/10000) by reciprocal multiply
    assign recip_prod = tfe_pkg::RecipProdW'(r_plo1) *
                        tfe_pkg::RecipProdW'(tfe_pkg::RecipMul);
    assign sum = tfe_pkg::SumW'(r_hi2) + tfe_pkg::SumW'(r_lo2);
    assign est = (sum > tfe_pkg::SumW'(r_rec2.max_fee)) ? r_rec2.max_fee
                                                       : sum[tfe_pkg::AmtW-1:0];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hi1  <= tfe_pkg::HiW'(i_split.quot) * tfe_pkg::HiW'(i_rec.bp);
            r_plo1 <= tfe_pkg::LoProdW'(i_split.rem) * tfe_pkg::LoProdW'(i_rec.bp);
            r_rec1 <= i_rec;
            r_hi2  <= r_hi1;
            r_lo2  <= recip_prod[tfe_pkg::RecipShift +: tfe_pkg::BpW];
            r_rec2 <= r_rec1;
            r_orec <= r_rec2;
            r_est  <= est;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v1 <= !i_empty;
            r_v2 <= r_v1;
            r_ov <= r_v2;
        end
    end

    assign o_valid = r_ov;
    assign o_found = r_orec.found;
    assign o_data  = {r_est, r_orec.max_fee, r_orec.bp};

endmodule

`default_nettype wire
